// ===== hw/rtl/bam_pkg.sv =====
// Package: shared types, constants and BCD arithmetic helpers for the decimal ALU.
package bam_pkg;

	localparam int MAX_DIGITS = 16;
	localparam int VEC_W      = 4 * MAX_DIGITS;
	localparam int NVEC       = 32;
	localparam int LEVELS     = 5;

	localparam logic [2:0] OP_ADD   = 3'd0;
	localparam logic [2:0] OP_MUL   = 3'd1;
	localparam logic [2:0] OP_TIMES = 3'd2;
	localparam logic [2:0] OP_SHIFT = 3'd3;
	localparam logic [2:0] OP_EQ    = 3'd4;

	localparam logic [VEC_W-1:0] SIXES = {MAX_DIGITS{4'h6}};

	typedef logic [VEC_W-1:0] bcd_t;

	typedef struct packed {
		logic is_equal;
		logic invalid_digit;
	} flags_t;

	// x + y in packed BCD, both valid BCD; binary add with +6 bias, then undo bias
	// on digits that produced no carry.
	function automatic bcd_t bcd_add(bcd_t x, bcd_t y, bcd_t mask);
		logic [VEC_W:0] s;
		logic [VEC_W:0] c;
		bcd_t           t1;
		bcd_t           r;
		logic [3:0]     dg;
		t1 = x + SIXES;
		s  = {1'b0, t1} + {1'b0, y};
		c  = s ^ {1'b0, t1} ^ {1'b0, y};
		for (int i = 0; i < MAX_DIGITS; i++) begin
			dg = s[4*i +: 4];
			r[4*i +: 4] = c[4*i+4] ? dg : dg - 4'd6;
		end
		return r & mask;
	endfunction

	// digit times digit: {tens, units}
	function automatic logic [7:0] dmul(logic [3:0] a, logic [3:0] b);
		logic [6:0]  p;
		logic [17:0] q;
		logic [3:0]  t;
		p = 7'(a) * 7'(b);
		q = 18'(p) * 18'd205;
		t = q[14:11];
		return {t, 4'(p - 7'(t) * 7'd10)};
	endfunction

endpackage

// ===== hw/rtl/bam_if.sv =====
// Interfaces: request and response channels of the decimal ALU.
interface bam_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] req_type;
	logic [63:0] operand_a;
	logic [63:0] operand_b;
	logic [4:0] small_operand;

	modport source (output valid, req_type, operand_a, operand_b, small_operand, input ready);
	modport sink   (input valid, req_type, operand_a, operand_b, small_operand, output ready);
endinterface

interface bam_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_value;
	logic        is_equal;
	logic        invalid_digit;

	modport source (output valid, result_value, is_equal, invalid_digit, input ready);
	modport sink   (input valid, result_value, is_equal, invalid_digit, output ready);
endinterface

// ===== hw/rtl/bam_front.sv =====
// Front stage: operand checks, digit products and selection of the vectors to sum.
module bam_front #(
	parameter int DIGITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [2:0]                   req_type,
	input  bam_pkg::bcd_t                operand_a,
	input  bam_pkg::bcd_t                operand_b,
	input  logic [4:0]                   small_operand,
	output logic                         valid_s1,
	output bam_pkg::flags_t              flags_s1,
	output bam_pkg::bcd_t                vec_s1 [bam_pkg::NVEC]
);
	import bam_pkg::*;

	localparam bcd_t MASK = bcd_t'({(4*DIGITS){1'b1}});

	bcd_t       am, bm;
	logic       bad_a, bad_b;
	logic [3:0] da [MAX_DIGITS];
	logic [3:0] db [MAX_DIGITS];
	bcd_t       mv [NVEC];
	bcd_t       tv [4];
	bcd_t       sh;
	bcd_t       v  [NVEC];
	flags_t     fl;
	logic [1:0] kt;
	logic [3:0] ku;
	logic [7:0] pd;

	always_comb begin
		am    = operand_a & MASK;
		bm    = operand_b & MASK;
		bad_a = 1'b0;
		bad_b = 1'b0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			da[i] = am[4*i +: 4];
			db[i] = bm[4*i +: 4];
			if (da[i] > 4'd9) bad_a = 1'b1;
			if (db[i] > 4'd9) bad_b = 1'b1;
		end

		for (int i = 0; i < NVEC; i++) mv[i] = '0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			for (int j = 0; j < MAX_DIGITS; j++) begin
				pd = dmul(da[j], db[i]);
				if (i + j < MAX_DIGITS)     mv[2*i][4*(i+j) +: 4]     = pd[3:0];
				if (i + j + 1 < MAX_DIGITS) mv[2*i+1][4*(i+j+1) +: 4] = pd[7:4];
			end
		end

		if (small_operand >= 5'd30)      kt = 2'd3;
		else if (small_operand >= 5'd20) kt = 2'd2;
		else if (small_operand >= 5'd10) kt = 2'd1;
		else                             kt = 2'd0;
		ku = 4'(small_operand - 5'(kt) * 5'd10);
		for (int i = 0; i < 4; i++) tv[i] = '0;
		for (int j = 0; j < MAX_DIGITS; j++) begin
			pd = dmul(da[j], ku);
			tv[0][4*j +: 4] = pd[3:0];
			if (j + 1 < MAX_DIGITS) tv[1][4*(j+1) +: 4] = pd[7:4];
			pd = dmul(da[j], {2'b00, kt});
			if (j + 1 < MAX_DIGITS) tv[2][4*(j+1) +: 4] = pd[3:0];
			if (j + 2 < MAX_DIGITS) tv[3][4*(j+2) +: 4] = pd[7:4];
		end

		sh = (small_operand < 5'(DIGITS)) ? (am << {small_operand, 2'b00}) : '0;

		for (int i = 0; i < NVEC; i++) v[i] = '0;
		fl = '0;
		unique case (req_type)
			OP_ADD: begin
				if (bad_a || bad_b) fl.invalid_digit = 1'b1;
				else begin
					v[0] = am;
					v[1] = bm;
				end
			end
			OP_MUL: begin
				if (bad_a || bad_b) fl.invalid_digit = 1'b1;
				else for (int i = 0; i < NVEC; i++) v[i] = mv[i];
			end
			OP_TIMES: begin
				if (bad_a) fl.invalid_digit = 1'b1;
				else for (int i = 0; i < 4; i++) v[i] = tv[i];
			end
			OP_SHIFT: begin
				if (bad_a) fl.invalid_digit = 1'b1;
				else v[0] = sh;
			end
			OP_EQ: begin
				if (bad_a || bad_b) fl.invalid_digit = 1'b1;
				else fl.is_equal = (am == bm);
			end
			default: ;
		endcase
		for (int i = 0; i < NVEC; i++) v[i] = v[i] & MASK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s1 <= fl;
			for (int i = 0; i < NVEC; i++) vec_s1[i] <= v[i];
		end
	end

endmodule

// ===== hw/rtl/bam_level.sv =====
// Adder tree level: registered pairwise BCD sums of N vectors.
module bam_level #(
	parameter int DIGITS = 16,
	parameter int N      = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  bam_pkg::flags_t      in_flags,
	input  bam_pkg::bcd_t        vin  [bam_pkg::NVEC],
	output logic                 out_valid,
	output bam_pkg::flags_t      out_flags,
	output bam_pkg::bcd_t        vout [bam_pkg::NVEC]
);
	import bam_pkg::*;

	localparam bcd_t MASK = bcd_t'({(4*DIGITS){1'b1}});
	localparam int   M    = N / 2;

	bcd_t sum_q [M];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_flags <= in_flags;
			for (int k = 0; k < M; k++) sum_q[k] <= bcd_add(vin[2*k], vin[2*k+1], MASK);
		end
	end

	always_comb begin
		for (int k = 0; k < NVEC; k++) vout[k] = '0;
		for (int k = 0; k < M; k++) vout[k] = sum_q[k];
	end

endmodule

// ===== hw/rtl/bcd_add_multiply_alu.sv =====
// Top level: pipelined packed-BCD ALU (add, multiply, digit multiply, shift, equality).
//
// Requests enter on req (valid/ready); each request yields exactly one response on rsp.
// Operands are packed BCD, DIGITS digits, digit 0 in the low nibble; results wrap
// modulo ten to the DIGITS. A nibble above 9 in a used operand flags invalid_digit
// and zeroes the result.
// Pipeline: one front stage forms up to 32 partial vectors (digit products for
// multiply), then a five-level registered BCD adder tree reduces them.
// Each request is registered in the front stage and then in every tree level before rsp.
// Throughput: one request per cycle while rsp is not stalled; the single pipeline has no loops.
// Stall: the whole pipeline holds when rsp.valid is high and rsp.ready is low;
// req.ready is then low, so nothing is lost or repeated. Bubbles are filled
// when the output is empty or being taken.
// Reset: arst_n clears all stage valid bits; no response is pending afterwards.
module bcd_add_multiply_alu #(
	parameter int DIGITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	bam_req_if.sink   req,
	bam_rsp_if.source rsp
);
	import bam_pkg::*;

	logic   en;
	logic   lvalid [LEVELS+1];
	flags_t lflags [LEVELS+1];
	bcd_t   lv     [LEVELS+1][NVEC];

	assign en        = !rsp.valid || rsp.ready;
	assign req.ready = en;

	bam_front #(.DIGITS(DIGITS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (req.valid),
		.req_type      (req.req_type),
		.operand_a     (req.operand_a),
		.operand_b     (req.operand_b),
		.small_operand (req.small_operand),
		.valid_s1      (lvalid[0]),
		.flags_s1      (lflags[0]),
		.vec_s1        (lv[0])
	);

	for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
		bam_level #(.DIGITS(DIGITS), .N(NVEC >> l)) u_level (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (lvalid[l]),
			.in_flags  (lflags[l]),
			.vin       (lv[l]),
			.out_valid (lvalid[l+1]),
			.out_flags (lflags[l+1]),
			.vout      (lv[l+1])
		);
	end

	assign rsp.valid         = lvalid[LEVELS];
	assign rsp.result_value  = lv[LEVELS][0];
	assign rsp.is_equal      = lflags[LEVELS].is_equal;
	assign rsp.invalid_digit = lflags[LEVELS].invalid_digit;

endmodule

// ===== hw/rtl/bam_chk.sv =====
// Checker: port-level properties of the decimal ALU, bound to the top level.
module bam_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [63:0] rsp_result_value,
	input logic        rsp_is_equal,
	input logic        rsp_invalid_digit
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value))
		else $error("stalled response changed");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken while output stalled");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_invalid_digit |-> rsp_result_value == 64'd0 && !rsp_is_equal)
		else $error("invalid digit with nonzero result");

	a_eq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_is_equal |-> rsp_result_value == 64'd0)
		else $error("equality with nonzero result");

	a_reset: assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("response valid during reset");

endmodule

bind bcd_add_multiply_alu bam_chk u_bam_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_result_value  (rsp.result_value),
	.rsp_is_equal      (rsp.is_equal),
	.rsp_invalid_digit (rsp.invalid_digit)
);
